@@ sv/crfe_pkg.sv @@
// ----------------------------------------------------------------------------
// crfe_pkg
// Shared types and constants of the clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package crfe_pkg;

    localparam int CoordW  = 16;
    localparam int ScreenW = 13;
    localparam int StrideW = 16;
    localparam int AddrW   = 32;
    localparam int DataW   = 32;
    localparam int BytesW  = 3;
    localparam int ColOffW = 15;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PIXEL_FORMAT  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LINE_STRIDE   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BUFFER_BASE   = 3'd4;

    localparam logic [1:0] FMT_UNKNOWN  = 2'd0;
    localparam logic [1:0] FMT_RGB565   = 2'd1;
    localparam logic [1:0] FMT_RGB888   = 2'd2;
    localparam logic [1:0] FMT_RGBA8888 = 2'd3;

    localparam logic ACT_FILL    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic [7:0] MASK_565_RB = 8'hF8;
    localparam logic [7:0] MASK_565_G  = 8'hFC;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_ADDR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic cfg_en;
        logic load_cmd;
        logic clip;
        logic calc_addr;
        logic step;
        logic out_load_pix;
        logic out_load_err;
    } t_dp_cmd;

    typedef struct packed {
        logic drop;
        logic fmt_bad;
        logic empty;
        logic last;
    } t_dp_stat;

endpackage

@@ sv/clipped_rect_fill_engine.sv @@
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine
// Clipped rectangle fill engine producing one framebuffer pixel write per advance item.
// ----------------------------------------------------------------------------
// A fill item is taken in the idle state and then holds the input off while
// the clip state orders and clips the corners and the address state forms the
// start address with the stride-times-row multiplier; a fill that is dropped,
// clips to nothing or meets an unknown pixel format returns to idle from the
// clip state instead. The unknown format yields one error item at that point
// unless the fill is also dropped, since the drop check wins. During a
// run each advance item yields one pixel write in the following cycle, and one
// advance item is accepted per cycle as long as the receiver takes each write;
// a write that still waits holds the input back. A fill item that arrives
// during a run is consumed and ignored, as is an advance item while idle.
// Configuration writes are held off during command setup, take effect only
// while idle and are consumed and ignored during a run.
module clipped_rect_fill_engine import crfe_pkg::*; #(
    parameter int MAX_SCREEN = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [DataW-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic signed [CoordW-1:0] i_corner_x1,
    input  logic signed [CoordW-1:0] i_corner_y1,
    input  logic signed [CoordW-1:0] i_corner_x2,
    input  logic signed [CoordW-1:0] i_corner_y2,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [AddrW-1:0]         o_write_address,
    output logic [DataW-1:0]         o_write_data,
    output logic [BytesW-1:0]        o_write_bytes,
    output logic                     o_last_write,
    output logic                     o_format_error
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    crfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    crfe_datapath #(
        .MAX_SCREEN (MAX_SCREEN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_corner_x1     (i_corner_x1),
        .i_corner_y1     (i_corner_y1),
        .i_corner_x2     (i_corner_x2),
        .i_corner_y2     (i_corner_y2),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_write_bytes   (o_write_bytes),
        .o_last_write    (o_last_write),
        .o_format_error  (o_format_error)
    );

endmodule

@@ sv/crfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// crfe_ctrl
// Sequencer of the fill engine: command setup, pixel run and output handshake.
// ----------------------------------------------------------------------------
module crfe_ctrl import crfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_action,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_fire;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = (r_state == ST_IDLE) || (r_state == ST_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.cfg_en = i_cfg_valid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                if (in_fire && (i_action == ACT_FILL)) begin
                    o_cmd.load_cmd = 1'b1;
                    n_state        = ST_CLIP;
                end
            end
            ST_CLIP: begin
                if (i_stat.drop) begin
                    n_state = ST_IDLE;
                end else if (i_stat.fmt_bad) begin
                    o_cmd.out_load_err = 1'b1;
                    n_state            = ST_IDLE;
                end else if (i_stat.empty) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.clip = 1'b1;
                    n_state    = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = ST_RUN;
            end
            ST_RUN: begin
                o_in_ready = out_free;
                if (in_fire && (i_action == ACT_ADVANCE)) begin
                    o_cmd.out_load_pix = 1'b1;
                    o_cmd.step         = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load_pix || o_cmd.out_load_err) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

@@ sv/crfe_datapath.sv @@
// ----------------------------------------------------------------------------
// crfe_datapath
// Settings, clipping, start address, pixel counters and the output register.
// ----------------------------------------------------------------------------
module crfe_datapath import crfe_pkg::*; #(
    parameter int MAX_SCREEN = 4096
) (
    input  logic                     i_clk,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [DataW-1:0]         i_cfg_data,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic signed [CoordW-1:0] i_corner_x1,
    input  logic signed [CoordW-1:0] i_corner_y1,
    input  logic signed [CoordW-1:0] i_corner_x2,
    input  logic signed [CoordW-1:0] i_corner_y2,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    output logic [AddrW-1:0]         o_write_address,
    output logic [DataW-1:0]         o_write_data,
    output logic [BytesW-1:0]        o_write_bytes,
    output logic                     o_last_write,
    output logic                     o_format_error
);

    localparam int ScreenMax = (1 << ScreenW) - 1;
    localparam int RowProdW  = StrideW + ScreenW;
    localparam logic [ScreenW-1:0] ScreenCap =
        (MAX_SCREEN > ScreenMax) ? ScreenW'(ScreenMax) : ScreenW'(MAX_SCREEN);

    logic [ScreenW-1:0]        r_screen_width;
    logic [ScreenW-1:0]        r_screen_height;
    logic [1:0]                r_pixel_format;
    logic [StrideW-1:0]        r_line_stride;
    logic [AddrW-1:0]          r_buffer_base;

    logic signed [CoordW-1:0]  r_x1, r_y1, r_x2, r_y2;
    logic [7:0]                r_red, r_green, r_blue;

    logic [ScreenW-1:0]        r_start_col, r_start_row;
    logic [ScreenW-1:0]        r_span_cols, r_span_rows;
    logic [ScreenW-1:0]        r_col_idx, r_row_idx;
    logic [ColOffW-1:0]        r_col_off;
    logic [AddrW-1:0]          r_row_addr;
    logic [DataW-1:0]          r_pixel_word;
    logic [BytesW-1:0]         r_bytes;

    logic [ScreenW-1:0]        sat_w, sat_h;
    logic signed [CoordW:0]    w_s, h_s;
    logic signed [CoordW:0]    min_x, max_x, min_y, max_y;
    logic signed [CoordW:0]    clip_min_x, clip_max_x, clip_min_y, clip_max_y;
    logic signed [CoordW:0]    span_x, span_y;
    logic [BytesW-1:0]         fmt_bytes;
    logic [DataW-1:0]          fmt_word;
    logic [AddrW-1:0]          row_term;
    logic [ColOffW-1:0]        col_term;
    logic                      row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= '0;
            r_screen_height <= '0;
            r_pixel_format  <= FMT_UNKNOWN;
            r_line_stride   <= '0;
            r_buffer_base   <= '0;
        end else if (i_cmd.cfg_en) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[ScreenW-1:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[ScreenW-1:0];
                REG_PIXEL_FORMAT:  r_pixel_format  <= i_cfg_data[1:0];
                REG_LINE_STRIDE:   r_line_stride   <= i_cfg_data[StrideW-1:0];
                REG_BUFFER_BASE:   r_buffer_base   <= i_cfg_data[AddrW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sat_w = (r_screen_width > ScreenCap) ? ScreenCap : r_screen_width;
        sat_h = (r_screen_height > ScreenCap) ? ScreenCap : r_screen_height;
        w_s   = $signed({{(CoordW + 1 - ScreenW){1'b0}}, sat_w});
        h_s   = $signed({{(CoordW + 1 - ScreenW){1'b0}}, sat_h});

        min_x = (r_x1 < r_x2) ? (CoordW + 1)'(r_x1) : (CoordW + 1)'(r_x2);
        max_x = (r_x1 < r_x2) ? (CoordW + 1)'(r_x2) : (CoordW + 1)'(r_x1);
        min_y = (r_y1 < r_y2) ? (CoordW + 1)'(r_y1) : (CoordW + 1)'(r_y2);
        max_y = (r_y1 < r_y2) ? (CoordW + 1)'(r_y2) : (CoordW + 1)'(r_y1);

        clip_min_x = (min_x < 0) ? '0 : min_x;
        clip_min_y = (min_y < 0) ? '0 : min_y;
        clip_max_x = (max_x >= w_s) ? (w_s - (CoordW + 1)'(1)) : max_x;
        clip_max_y = (max_y >= h_s) ? (h_s - (CoordW + 1)'(1)) : max_y;
        span_x     = clip_max_x - clip_min_x + (CoordW + 1)'(1);
        span_y     = clip_max_y - clip_min_y + (CoordW + 1)'(1);

        o_stat.drop    = (min_x >= w_s) || (min_y >= h_s) || (max_x < 0) || (max_y < 0);
        o_stat.empty   = (clip_max_x < clip_min_x) || (clip_max_y < clip_min_y);

        o_stat.fmt_bad = 1'b0;
        case (r_pixel_format)
            FMT_RGB565: begin
                fmt_bytes = 3'd2;
                fmt_word  = {16'd0, r_blue[7:3] & MASK_565_RB[7:3],
                             r_green[7:2] & MASK_565_G[7:2], r_red[7:3]};
            end
            FMT_RGB888: begin
                fmt_bytes = 3'd3;
                fmt_word  = {8'd0, r_blue, r_green, r_red};
            end
            FMT_RGBA8888: begin
                fmt_bytes = 3'd4;
                fmt_word  = {ALPHA_OPAQUE, r_blue, r_green, r_red};
            end
            default: begin
                fmt_bytes      = '0;
                fmt_word       = '0;
                o_stat.fmt_bad = 1'b1;
            end
        endcase

        row_end     = ({1'b0, r_col_idx} + 1'b1) >= {1'b0, r_span_cols};
        o_stat.last = row_end && (({1'b0, r_row_idx} + 1'b1) >= {1'b0, r_span_rows});

        row_term = AddrW'(RowProdW'(r_line_stride) * RowProdW'(r_start_row));
        col_term = ColOffW'(r_start_col) * ColOffW'(r_bytes);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd) begin
            r_x1    <= i_corner_x1;
            r_y1    <= i_corner_y1;
            r_x2    <= i_corner_x2;
            r_y2    <= i_corner_y2;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (i_cmd.clip) begin
            r_start_col  <= clip_min_x[ScreenW-1:0];
            r_start_row  <= clip_min_y[ScreenW-1:0];
            r_span_cols  <= span_x[ScreenW-1:0];
            r_span_rows  <= span_y[ScreenW-1:0];
            r_bytes      <= fmt_bytes;
            r_pixel_word <= fmt_word;
        end
        if (i_cmd.calc_addr) begin
            r_row_addr <= r_buffer_base + row_term + AddrW'(col_term);
            r_col_idx  <= '0;
            r_row_idx  <= '0;
            r_col_off  <= '0;
        end else if (i_cmd.step) begin
            if (row_end) begin
                r_col_idx  <= '0;
                r_col_off  <= '0;
                r_row_idx  <= r_row_idx + 1'b1;
                r_row_addr <= r_row_addr + AddrW'(r_line_stride);
            end else begin
                r_col_idx <= r_col_idx + 1'b1;
                r_col_off <= r_col_off + ColOffW'(r_bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_pix) begin
            o_write_address <= r_row_addr + AddrW'(r_col_off);
            o_write_data    <= r_pixel_word;
            o_write_bytes   <= r_bytes;
            o_last_write    <= o_stat.last;
            o_format_error  <= 1'b0;
        end else if (i_cmd.out_load_err) begin
            o_write_address <= '0;
            o_write_data    <= '0;
            o_write_bytes   <= '0;
            o_last_write    <= 1'b0;
            o_format_error  <= 1'b1;
        end
    end

endmodule
